### src/pbpbf_pkg.sv
// Shared types, constants and tables of the polar beam to point box filter.
`timescale 1ns / 1ps

package pbpbf_pkg;

    localparam int W_COORD   = 40;
    localparam int W_ANG     = 26;
    localparam int W_RAD     = 20;
    localparam int W_CNT     = 8;
    localparam int W_RANGE   = 27;
    localparam int W_REFL    = 32;
    localparam int W_DIR     = 32;
    localparam int W_MUL     = 32;
    localparam int W_PROD    = 2 * W_MUL;
    localparam int W_CFG_IDX = 3;
    localparam int W_CXY     = 34;
    localparam int W_CZ      = 26;
    localparam int W_STEP    = 5;

    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_GAIN  = 652032874;

    localparam int DEG_ONE     = 65536;
    localparam int DEG_HALF    = 180 * DEG_ONE;
    localparam int DEG_QUARTER = DEG_HALF / 2;
    localparam int DEG_TURN    = 2 * DEG_HALF;
    localparam int DEG_CLAMP   = 360 * DEG_ONE;

    // pi/180 in Q.32, applied as two partial products of 16 and 11 bits
    localparam int RAD_K      = 74961321;
    localparam int RAD_K_LO   = RAD_K % 65536;
    localparam int RAD_K_HI   = RAD_K / 65536;
    localparam int W_PLO      = W_ANG + 16;
    localparam int W_RSUM     = 52;

    localparam logic [W_CFG_IDX-1:0] CFG_X_MIN = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_Y_MIN = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_Z_MIN = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_X_MAX = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_Y_MAX = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_Z_MAX = 3'd5;

    localparam logic OPC_HEADER = 1'b0;
    localparam logic OPC_HIT    = 1'b1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HDR_LOAD,
        OP_HIT_LOAD,
        OP_RAD_LO,
        OP_RAD_HI,
        OP_RAD_FIN,
        OP_COR_INIT,
        OP_COR_STEP,
        OP_COR_END,
        OP_MUL_SC,
        OP_MUL_SS,
        OP_DIR_FIN,
        OP_PT_MUL,
        OP_PT_FIN,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [1:0]        sel;
        logic [W_STEP-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic hit_ok;
        logic in_box;
        logic out_busy;
    } t_status;

    // Arctangent of 2^-i in degrees, Q.16
    function automatic logic signed [W_CZ-1:0] cordic_atan(input logic [W_STEP-1:0] i);
        logic signed [W_CZ-1:0] v;
        case (i)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/pbpbf_ctrl.sv
// Controller state machine sequencing header and hit processing.
`timescale 1ns / 1ps

module pbpbf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_opcode,
    input  pbpbf_pkg::t_status i_status,
    output logic               o_in_ready,
    output pbpbf_pkg::t_cmd    o_cmd
);
    import pbpbf_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_RAD_LO   = 15'h0002,
        S_RAD_HI   = 15'h0004,
        S_RAD_FIN  = 15'h0008,
        S_COR_INIT = 15'h0010,
        S_COR_STEP = 15'h0020,
        S_COR_END  = 15'h0040,
        S_MUL_SC   = 15'h0080,
        S_MUL_SS   = 15'h0100,
        S_DIR_FIN  = 15'h0200,
        S_HIT_X    = 15'h0400,
        S_HIT_Y    = 15'h0800,
        S_HIT_Z    = 15'h1000,
        S_HIT_FIN  = 15'h2000,
        S_CHECK    = 15'h4000
    } t_state;

    localparam logic [W_STEP-1:0] LAST_STEP = W_STEP'(CORDIC_STEPS - 1);

    t_state            r_state, n_state;
    logic              r_ang, n_ang;
    logic [W_STEP-1:0] r_step, n_step;
    logic              accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_ang      = r_ang;
        n_step     = r_step;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = {1'b0, r_ang};
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_opcode == OPC_HEADER) begin
                    o_cmd.op = OP_HDR_LOAD;
                    n_ang    = 1'b0;
                    n_state  = S_RAD_LO;
                end else if (accept && i_status.hit_ok) begin
                    o_cmd.op = OP_HIT_LOAD;
                    n_state  = S_HIT_X;
                end
            end
            S_RAD_LO: begin
                o_cmd.op = OP_RAD_LO;
                n_state  = S_RAD_HI;
            end
            S_RAD_HI: begin
                o_cmd.op = OP_RAD_HI;
                n_state  = S_RAD_FIN;
            end
            S_RAD_FIN: begin
                o_cmd.op = OP_RAD_FIN;
                n_state  = S_COR_INIT;
            end
            S_COR_INIT: begin
                o_cmd.op = OP_COR_INIT;
                n_step   = '0;
                n_state  = S_COR_STEP;
            end
            S_COR_STEP: begin
                o_cmd.op = OP_COR_STEP;
                n_step   = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_COR_END;
                end
            end
            S_COR_END: begin
                o_cmd.op = OP_COR_END;
                if (!r_ang) begin
                    n_ang   = 1'b1;
                    n_state = S_RAD_LO;
                end else begin
                    n_state = S_MUL_SC;
                end
            end
            S_MUL_SC: begin
                o_cmd.op = OP_MUL_SC;
                n_state  = S_MUL_SS;
            end
            S_MUL_SS: begin
                o_cmd.op = OP_MUL_SS;
                n_state  = S_DIR_FIN;
            end
            S_DIR_FIN: begin
                o_cmd.op = OP_DIR_FIN;
                n_state  = S_IDLE;
            end
            S_HIT_X: begin
                o_cmd.op  = OP_PT_MUL;
                o_cmd.sel = AXIS_X;
                n_state   = S_HIT_Y;
            end
            S_HIT_Y: begin
                o_cmd.op  = OP_PT_MUL;
                o_cmd.sel = AXIS_Y;
                n_state   = S_HIT_Z;
            end
            S_HIT_Z: begin
                o_cmd.op  = OP_PT_MUL;
                o_cmd.sel = AXIS_Z;
                n_state   = S_HIT_FIN;
            end
            S_HIT_FIN: begin
                o_cmd.op = OP_PT_FIN;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                // A point outside the box is dropped; one inside waits for a free output.
                if (!i_status.in_box) begin
                    n_state = S_IDLE;
                end else if (!i_status.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ang   <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ang   <= n_ang;
            r_step  <= n_step;
        end
    end

endmodule

### src/pbpbf_dp.sv
// Datapath: beam state, shared multiplier, CORDIC unit, box check and output register.
`timescale 1ns / 1ps

module pbpbf_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  pbpbf_pkg::t_cmd                         i_cmd,
    input  logic                                    i_cfg_we,
    input  logic [pbpbf_pkg::W_CFG_IDX-1:0]         i_cfg_index,
    input  logic [pbpbf_pkg::W_COORD-1:0]           i_cfg_data,
    input  logic signed [pbpbf_pkg::W_ANG-1:0]      i_zenith_deg,
    input  logic signed [pbpbf_pkg::W_ANG-1:0]      i_azimuth_deg,
    input  logic signed [pbpbf_pkg::W_COORD-1:0]    i_centre_x,
    input  logic signed [pbpbf_pkg::W_COORD-1:0]    i_centre_y,
    input  logic signed [pbpbf_pkg::W_COORD-1:0]    i_centre_z,
    input  logic [pbpbf_pkg::W_CNT-1:0]             i_hits_in_beam,
    input  logic [pbpbf_pkg::W_RANGE-1:0]           i_hit_range,
    input  logic signed [pbpbf_pkg::W_REFL-1:0]     i_hit_reflectance,
    input  logic                                    i_out_ready,
    output pbpbf_pkg::t_status                      o_status,
    output logic                                    o_out_valid,
    output logic signed [pbpbf_pkg::W_COORD-1:0]    o_point_x,
    output logic signed [pbpbf_pkg::W_COORD-1:0]    o_point_y,
    output logic signed [pbpbf_pkg::W_COORD-1:0]    o_point_z,
    output logic signed [pbpbf_pkg::W_REFL-1:0]     o_point_reflectance,
    output logic [pbpbf_pkg::W_CNT-1:0]             o_hit_number,
    output logic [pbpbf_pkg::W_CNT-1:0]             o_beam_hit_total,
    output logic signed [pbpbf_pkg::W_RAD-1:0]      o_zenith_rad,
    output logic signed [pbpbf_pkg::W_RAD-1:0]      o_azimuth_rad,
    output logic [pbpbf_pkg::W_RANGE-1:0]           o_point_range
);
    import pbpbf_pkg::*;

    localparam int W_AE  = W_ANG + 1;
    localparam int W_SUM = W_COORD + 1;

    localparam logic signed [W_ANG-1:0]   CLAMP_P = W_ANG'(DEG_CLAMP);
    localparam logic signed [W_ANG-1:0]   CLAMP_N = W_ANG'(-DEG_CLAMP);
    localparam logic signed [W_AE-1:0]    HALF_P  = W_AE'(DEG_HALF);
    localparam logic signed [W_AE-1:0]    HALF_N  = W_AE'(-DEG_HALF);
    localparam logic signed [W_AE-1:0]    QUART_P = W_AE'(DEG_QUARTER);
    localparam logic signed [W_AE-1:0]    QUART_N = W_AE'(-DEG_QUARTER);
    localparam logic signed [W_AE-1:0]    TURN    = W_AE'(DEG_TURN);
    localparam logic signed [W_PROD-1:0]  RND30   = W_PROD'(64'sd1 <<< 29);
    localparam logic signed [W_PROD-1:0]  RND36   = W_PROD'(64'sd1 <<< 35);
    localparam logic [W_RSUM-1:0]         RND32   = W_RSUM'(64'd1 << 31);
    localparam logic signed [W_COORD-1:0] C_MAX   = {1'b0, {(W_COORD-1){1'b1}}};
    localparam logic signed [W_COORD-1:0] C_MIN   = {1'b1, {(W_COORD-1){1'b0}}};

    // configuration
    logic signed [W_COORD-1:0] r_box_min [3];
    logic signed [W_COORD-1:0] r_box_max [3];

    // beam state
    logic signed [W_ANG-1:0]   r_zen, r_az;
    logic signed [W_COORD-1:0] r_centre [3];
    logic signed [W_RAD-1:0]   r_rad [2];
    logic [W_CNT-1:0]          r_total, r_next_idx;
    logic signed [W_DIR-1:0]   r_dir [3];
    logic signed [W_DIR-1:0]   r_sz, r_sa, r_ca;

    // working registers
    logic signed [W_PROD-1:0]  r_prod;
    logic [W_PLO-1:0]          r_plo;
    logic signed [W_CXY-1:0]   r_x, r_y;
    logic signed [W_CZ-1:0]    r_z;
    logic                      r_neg;
    logic [W_RANGE-1:0]        r_range;
    logic signed [W_REFL-1:0]  r_refl;
    logic [W_CNT-1:0]          r_hit_idx;
    logic signed [W_COORD-1:0] r_pt [3];

    // output register
    logic                      r_out_valid;
    logic signed [W_COORD-1:0] r_o_x, r_o_y, r_o_z;
    logic signed [W_REFL-1:0]  r_o_refl;
    logic [W_CNT-1:0]          r_o_idx, r_o_total;
    logic signed [W_RAD-1:0]   r_o_zen, r_o_az;
    logic [W_RANGE-1:0]        r_o_range;

    logic signed [W_ANG-1:0]   zen_clamped, az_clamped, ang_sel;
    logic [W_ANG-1:0]          ang_abs;
    logic signed [W_MUL-1:0]   mul_a, mul_b;
    logic signed [W_PROD-1:0]  mul_p;
    logic [W_RSUM-1:0]         rad_sum;
    logic [W_RAD-1:0]          rad_mag;
    logic signed [W_RAD-1:0]   rad_val;
    logic signed [W_AE-1:0]    d0, d1, d2;
    logic                      fold_neg;
    logic signed [W_CXY-1:0]   xs, ys;
    logic signed [W_CZ-1:0]    atan_i;
    logic signed [W_DIR-1:0]   cos_val;
    logic signed [W_PROD-1:0]  dir_tmp, pt_tmp, pt_sh;
    logic [1:0]                pt_idx;
    logic signed [W_SUM-1:0]   pt_sum;
    logic signed [W_COORD-1:0] pt_sat;
    logic                      in_box;

    always_comb begin
        zen_clamped = i_zenith_deg;
        if (i_zenith_deg > CLAMP_P) begin
            zen_clamped = CLAMP_P;
        end else if (i_zenith_deg < CLAMP_N) begin
            zen_clamped = CLAMP_N;
        end
        az_clamped = i_azimuth_deg;
        if (i_azimuth_deg > CLAMP_P) begin
            az_clamped = CLAMP_P;
        end else if (i_azimuth_deg < CLAMP_N) begin
            az_clamped = CLAMP_N;
        end
    end

    assign ang_sel = i_cmd.sel[0] ? r_az : r_zen;
    assign ang_abs = ang_sel[W_ANG-1] ? W_ANG'(-ang_sel) : W_ANG'(ang_sel);

    // One shared multiplier, operands chosen by the command.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_RAD_LO: begin
                mul_a = signed'(W_MUL'(ang_abs));
                mul_b = W_MUL'(RAD_K_LO);
            end
            OP_RAD_HI: begin
                mul_a = signed'(W_MUL'(ang_abs));
                mul_b = W_MUL'(RAD_K_HI);
            end
            OP_MUL_SC: begin
                mul_a = r_sz;
                mul_b = r_ca;
            end
            OP_MUL_SS: begin
                mul_a = r_sz;
                mul_b = r_sa;
            end
            OP_PT_MUL: begin
                mul_a = signed'(W_MUL'(r_range));
                mul_b = r_dir[i_cmd.sel];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Degrees to radians, rounded half away from zero on the magnitude.
    assign rad_sum = (W_RSUM'(r_prod) << 16) + W_RSUM'(r_plo) + RND32;
    assign rad_mag = rad_sum[W_RSUM-1:32];
    assign rad_val = ang_sel[W_ANG-1] ? W_RAD'(-signed'(rad_mag)) : signed'(rad_mag);

    // Wrap into one half turn either side, then fold into the right half plane.
    always_comb begin
        d0 = W_AE'(ang_sel);
        d1 = d0;
        if (d0 > HALF_P) begin
            d1 = d0 - TURN;
        end else if (d0 < HALF_N) begin
            d1 = d0 + TURN;
        end
        d2       = d1;
        fold_neg = 1'b0;
        if (d1 > QUART_P) begin
            d2       = HALF_P - d1;
            fold_neg = 1'b1;
        end else if (d1 < QUART_N) begin
            d2       = HALF_N - d1;
            fold_neg = 1'b1;
        end
    end

    assign xs      = r_x >>> i_cmd.step;
    assign ys      = r_y >>> i_cmd.step;
    assign atan_i  = cordic_atan(i_cmd.step);
    assign cos_val = r_neg ? W_DIR'(-r_x) : W_DIR'(r_x);

    assign dir_tmp = r_prod + RND30;
    assign pt_tmp  = r_prod + RND36;
    assign pt_sh   = pt_tmp >>> 36;
    assign pt_idx  = (i_cmd.op == OP_PT_FIN) ? AXIS_Z : i_cmd.sel - 1'b1;
    assign pt_sum  = W_SUM'(pt_sh) + W_SUM'(r_centre[pt_idx]);

    always_comb begin
        pt_sat = pt_sum[W_COORD-1:0];
        if (pt_sum[W_SUM-1] != pt_sum[W_COORD-1]) begin
            pt_sat = pt_sum[W_SUM-1] ? C_MIN : C_MAX;
        end
    end

    assign in_box = (r_pt[0] >= r_box_min[0]) && (r_pt[0] <= r_box_max[0]) &&
                    (r_pt[1] >= r_box_min[1]) && (r_pt[1] <= r_box_max[1]) &&
                    (r_pt[2] >= r_box_min[2]) && (r_pt[2] <= r_box_max[2]);

    assign o_status.hit_ok   = (r_next_idx < r_total);
    assign o_status.in_box   = in_box;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min[0] <= C_MIN;
            r_box_min[1] <= C_MIN;
            r_box_min[2] <= C_MIN;
            r_box_max[0] <= C_MAX;
            r_box_max[1] <= C_MAX;
            r_box_max[2] <= C_MAX;
            r_total      <= '0;
            r_next_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_X_MIN: r_box_min[0] <= signed'(i_cfg_data);
                    CFG_Y_MIN: r_box_min[1] <= signed'(i_cfg_data);
                    CFG_Z_MIN: r_box_min[2] <= signed'(i_cfg_data);
                    CFG_X_MAX: r_box_max[0] <= signed'(i_cfg_data);
                    CFG_Y_MAX: r_box_max[1] <= signed'(i_cfg_data);
                    CFG_Z_MAX: r_box_max[2] <= signed'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_HDR_LOAD) begin
                r_total    <= i_hits_in_beam;
                r_next_idx <= '0;
            end else if (i_cmd.op == OP_HIT_LOAD) begin
                r_next_idx <= r_next_idx + 1'b1;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            OP_HDR_LOAD: begin
                r_zen       <= zen_clamped;
                r_az        <= az_clamped;
                r_centre[0] <= i_centre_x;
                r_centre[1] <= i_centre_y;
                r_centre[2] <= i_centre_z;
            end
            OP_HIT_LOAD: begin
                r_range   <= i_hit_range;
                r_refl    <= i_hit_reflectance;
                r_hit_idx <= r_next_idx;
            end
            OP_RAD_HI: begin
                r_plo <= W_PLO'(r_prod);
            end
            OP_RAD_FIN: begin
                r_rad[i_cmd.sel[0]] <= rad_val;
            end
            OP_COR_INIT: begin
                r_x   <= W_CXY'(CORDIC_GAIN);
                r_y   <= '0;
                r_z   <= W_CZ'(d2);
                r_neg <= fold_neg;
            end
            OP_COR_STEP: begin
                if (!r_z[W_CZ-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_i;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_i;
                end
            end
            OP_COR_END: begin
                if (!i_cmd.sel[0]) begin
                    r_sz     <= W_DIR'(r_y);
                    r_dir[2] <= cos_val;
                end else begin
                    r_sa <= W_DIR'(r_y);
                    r_ca <= cos_val;
                end
            end
            OP_MUL_SS: begin
                r_dir[0] <= dir_tmp[W_DIR+29:30];
            end
            OP_DIR_FIN: begin
                r_dir[1] <= dir_tmp[W_DIR+29:30];
            end
            OP_PT_MUL: begin
                if (i_cmd.sel != AXIS_X) begin
                    r_pt[pt_idx] <= pt_sat;
                end
            end
            OP_PT_FIN: begin
                r_pt[pt_idx] <= pt_sat;
            end
            OP_EMIT: begin
                r_o_x     <= r_pt[0];
                r_o_y     <= r_pt[1];
                r_o_z     <= r_pt[2];
                r_o_refl  <= r_refl;
                r_o_idx   <= r_hit_idx;
                r_o_total <= r_total;
                r_o_zen   <= r_rad[0];
                r_o_az    <= r_rad[1];
                r_o_range <= r_range;
            end
            default: ;
        endcase
    end

    assign o_out_valid         = r_out_valid;
    assign o_point_x           = r_o_x;
    assign o_point_y           = r_o_y;
    assign o_point_z           = r_o_z;
    assign o_point_reflectance = r_o_refl;
    assign o_hit_number        = r_o_idx;
    assign o_beam_hit_total    = r_o_total;
    assign o_zenith_rad        = r_o_zen;
    assign o_azimuth_rad       = r_o_az;
    assign o_point_range       = r_o_range;

endmodule

### src/polar_beam_to_point_box_filter_core.sv
// Header: busy while each of the two angles passes radian conversion (low, high, finish) and
// the CORDIC loop (init, iterations, end), then the direction products. Hit: busy for three
// passes of the shared multiplier, then the box check, which emits once the output is free;
// no new request is taken meanwhile. A surplus hit is dropped in the cycle it is taken.
// Reset is synchronous and active low; it opens the box fully and clears the beam count.
`timescale 1ns / 1ps

module polar_beam_to_point_box_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pbpbf_pkg::W_CFG_IDX-1:0]      i_cfg_index,
    input  logic [pbpbf_pkg::W_COORD-1:0]        i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_opcode,
    input  logic signed [pbpbf_pkg::W_ANG-1:0]   i_zenith_deg,
    input  logic signed [pbpbf_pkg::W_ANG-1:0]   i_azimuth_deg,
    input  logic signed [pbpbf_pkg::W_COORD-1:0] i_centre_x,
    input  logic signed [pbpbf_pkg::W_COORD-1:0] i_centre_y,
    input  logic signed [pbpbf_pkg::W_COORD-1:0] i_centre_z,
    input  logic [pbpbf_pkg::W_CNT-1:0]          i_hits_in_beam,
    input  logic [pbpbf_pkg::W_RANGE-1:0]        i_hit_range,
    input  logic signed [pbpbf_pkg::W_REFL-1:0]  i_hit_reflectance,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pbpbf_pkg::W_COORD-1:0] o_point_x,
    output logic signed [pbpbf_pkg::W_COORD-1:0] o_point_y,
    output logic signed [pbpbf_pkg::W_COORD-1:0] o_point_z,
    output logic signed [pbpbf_pkg::W_REFL-1:0]  o_point_reflectance,
    output logic [pbpbf_pkg::W_CNT-1:0]          o_hit_number,
    output logic [pbpbf_pkg::W_CNT-1:0]          o_beam_hit_total,
    output logic signed [pbpbf_pkg::W_RAD-1:0]   o_zenith_rad,
    output logic signed [pbpbf_pkg::W_RAD-1:0]   o_azimuth_rad,
    output logic [pbpbf_pkg::W_RANGE-1:0]        o_point_range
);
    import pbpbf_pkg::*;

    t_cmd    cmd;
    t_status status;

    pbpbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    pbpbf_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_zenith_deg        (i_zenith_deg),
        .i_azimuth_deg       (i_azimuth_deg),
        .i_centre_x          (i_centre_x),
        .i_centre_y          (i_centre_y),
        .i_centre_z          (i_centre_z),
        .i_hits_in_beam      (i_hits_in_beam),
        .i_hit_range         (i_hit_range),
        .i_hit_reflectance   (i_hit_reflectance),
        .i_out_ready         (i_out_ready),
        .o_status            (status),
        .o_out_valid         (o_out_valid),
        .o_point_x           (o_point_x),
        .o_point_y           (o_point_y),
        .o_point_z           (o_point_z),
        .o_point_reflectance (o_point_reflectance),
        .o_hit_number        (o_hit_number),
        .o_beam_hit_total    (o_beam_hit_total),
        .o_zenith_rad        (o_zenith_rad),
        .o_azimuth_rad       (o_azimuth_rad),
        .o_point_range       (o_point_range)
    );

`ifndef SYNTH
    // A point is only produced from the box check, never straight from the idle state.
    a_emit_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("point emitted while the block was idle");

    a_index_in_beam: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_number < o_beam_hit_total))
        else $error("hit number not below the beam hit count");

    a_header_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OPC_HEADER)) |=> !o_in_ready)
        else $error("header request did not start the angle sequence");
`endif

endmodule

### tb/sv/polar_beam_to_point_box_filter_core_tb.sv
// Self-checking testbench of the polar beam to point box filter core.
`timescale 1ns / 1ps

module polar_beam_to_point_box_filter_core_tb;
    import pbpbf_pkg::*;

    typedef struct {
        logic                        opc;
        logic signed [W_ANG-1:0]     zen;
        logic signed [W_ANG-1:0]     az;
        logic signed [W_COORD-1:0]   cx, cy, cz;
        logic [W_CNT-1:0]            cnt;
        logic [W_RANGE-1:0]          rng;
        logic signed [W_REFL-1:0]    refl;
    } t_beam_item;

    typedef struct {
        logic signed [W_COORD-1:0]   px, py, pz;
        logic signed [W_REFL-1:0]    refl;
        logic [W_CNT-1:0]            idx;
        logic [W_CNT-1:0]            total;
        logic signed [W_RAD-1:0]     zen_rad, az_rad;
        logic [W_RANGE-1:0]          rng;
    } t_point;

    localparam longint ATAN_DEG [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };
    localparam longint COORD_MAX = (longint'(1) <<< 39) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< 39);

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [W_CFG_IDX-1:0]        i_cfg_index;
    logic [W_COORD-1:0]          i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_opcode;
    logic signed [W_ANG-1:0]     i_zenith_deg;
    logic signed [W_ANG-1:0]     i_azimuth_deg;
    logic signed [W_COORD-1:0]   i_centre_x;
    logic signed [W_COORD-1:0]   i_centre_y;
    logic signed [W_COORD-1:0]   i_centre_z;
    logic [W_CNT-1:0]            i_hits_in_beam;
    logic [W_RANGE-1:0]          i_hit_range;
    logic signed [W_REFL-1:0]    i_hit_reflectance;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [W_COORD-1:0]   o_point_x;
    logic signed [W_COORD-1:0]   o_point_y;
    logic signed [W_COORD-1:0]   o_point_z;
    logic signed [W_REFL-1:0]    o_point_reflectance;
    logic [W_CNT-1:0]            o_hit_number;
    logic [W_CNT-1:0]            o_beam_hit_total;
    logic signed [W_RAD-1:0]     o_zenith_rad;
    logic signed [W_RAD-1:0]     o_azimuth_rad;
    logic [W_RANGE-1:0]          o_point_range;

    polar_beam_to_point_box_filter_core dut (.*);

    // Predictor state: direction factors, held beam and box bounds.
    longint                  dir_f [3];
    longint                  held_ctr [3];
    logic signed [W_RAD-1:0] held_zen_rad, held_az_rad;
    int unsigned             beam_total, hit_idx;
    longint                  box_lo [3], box_hi [3];

    t_point   points_due [$];
    int       fail_count;
    int       items_sent;
    int       points_seen;
    int       hold_cycles;
    int       ready_gap;
    bit       no_gaps;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout at %0t", $time);
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint rshift_round(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint clamp_angle(input longint d);
        if (d > DEG_CLAMP) return DEG_CLAMP;
        if (d < -DEG_CLAMP) return -DEG_CLAMP;
        return d;
    endfunction

    function automatic longint radians_of(input longint d);
        longint mag, r;
        mag = (d < 0) ? -d : d;
        r = (mag * RAD_K + (longint'(1) <<< 31)) >>> 32;
        return (d < 0) ? -r : r;
    endfunction

    function automatic void sine_cosine(input longint d_in, output longint s, output longint c);
        longint d, x, y, z, xs, ys;
        bit     flip;
        d = d_in;
        flip = 1'b0;
        x = longint'(CORDIC_GAIN);
        y = 0;
        if (d > DEG_HALF) d -= DEG_TURN;
        if (d < -DEG_HALF) d += DEG_TURN;
        if (d > DEG_QUARTER) begin
            d = DEG_HALF - d;
            flip = 1'b1;
        end else if (d < -DEG_QUARTER) begin
            d = -DEG_HALF - d;
            flip = 1'b1;
        end
        z = d;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_DEG[i];
            end else begin
                x += ys; y -= xs; z += ATAN_DEG[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    // Updates the held beam or turns a hit into the point it should give.
    function automatic void predict_point(input t_beam_item it);
        longint zen, az, sz, cz, sa, ca, r, p [3];
        t_point pt;
        bit     in_box;
        if (it.opc == OPC_HEADER) begin
            zen = clamp_angle(longint'(it.zen));
            az  = clamp_angle(longint'(it.az));
            sine_cosine(zen, sz, cz);
            sine_cosine(az, sa, ca);
            dir_f[0] = rshift_round(sz * ca, 30);
            dir_f[1] = rshift_round(sz * sa, 30);
            dir_f[2] = cz;
            held_ctr[0] = longint'(it.cx);
            held_ctr[1] = longint'(it.cy);
            held_ctr[2] = longint'(it.cz);
            held_zen_rad = W_RAD'(radians_of(zen));
            held_az_rad  = W_RAD'(radians_of(az));
            beam_total = 32'(it.cnt);
            hit_idx = 0;
        end else if (hit_idx < beam_total) begin
            r = longint'({1'b0, it.rng});
            in_box = 1'b1;
            for (int a = 0; a < 3; a++) begin
                p[a] = sat_coord(rshift_round(r * dir_f[a], 36) + held_ctr[a]);
                if (p[a] < box_lo[a] || p[a] > box_hi[a]) in_box = 1'b0;
            end
            if (in_box) begin
                pt.px = W_COORD'(p[0]); pt.py = W_COORD'(p[1]); pt.pz = W_COORD'(p[2]);
                pt.refl = it.refl;
                pt.idx = hit_idx[W_CNT-1:0];
                pt.total = beam_total[W_CNT-1:0];
                pt.zen_rad = held_zen_rad;
                pt.az_rad = held_az_rad;
                pt.rng = it.rng;
                points_due.push_back(pt);
            end
            hit_idx++;
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        ready_gap = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (ready_gap > 0) begin
                i_out_ready <= 1'b0;
                ready_gap--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_gaps && $urandom_range(7) == 0)
                    ready_gap = ($urandom_range(9) == 0) ? $urandom_range(40, 12)
                                                          : $urandom_range(3, 1);
            end
        end
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            points_seen++;
            if (points_due.size() == 0) begin
                fail_count++;
                $display("%0t: point with no request pending, x %0d", $time, o_point_x);
            end else begin
                e = points_due.pop_front();
                if (o_point_x !== e.px || o_point_y !== e.py || o_point_z !== e.pz) begin
                    fail_count++;
                    $display("%0t: xyz expected %0d %0d %0d actual %0d %0d %0d", $time,
                             e.px, e.py, e.pz, o_point_x, o_point_y, o_point_z);
                end
                if (o_point_reflectance !== e.refl || o_point_range !== e.rng) begin
                    fail_count++;
                    $display("%0t: refl/range expected %0d %0d actual %0d %0d", $time,
                             e.refl, e.rng, o_point_reflectance, o_point_range);
                end
                if (o_hit_number !== e.idx || o_beam_hit_total !== e.total) begin
                    fail_count++;
                    $display("%0t: hit/total expected %0d %0d actual %0d %0d", $time,
                             e.idx, e.total, o_hit_number, o_beam_hit_total);
                end
                if (o_zenith_rad !== e.zen_rad || o_azimuth_rad !== e.az_rad) begin
                    fail_count++;
                    $display("%0t: rad expected %0d %0d actual %0d %0d", $time,
                             e.zen_rad, e.az_rad, o_zenith_rad, o_azimuth_rad);
                end
            end
        end
    end

    task automatic send_item(input t_beam_item it);
        int gap;
        i_opcode          <= it.opc;
        i_zenith_deg      <= it.zen;
        i_azimuth_deg     <= it.az;
        i_centre_x        <= it.cx;
        i_centre_y        <= it.cy;
        i_centre_z        <= it.cz;
        i_hits_in_beam    <= it.cnt;
        i_hit_range       <= it.rng;
        i_hit_reflectance <= it.refl;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_point(it);
        items_sent++;
        gap = 0;
        if (!no_gaps) begin
            case ($urandom_range(19))
                0:             gap = $urandom_range(60, 10);
                1, 2, 3, 4, 5: gap = $urandom_range(3, 1);
                default:       gap = 0;
            endcase
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The caller releases the write enable after the last write.
    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input longint value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[W_COORD-1:0];
        @(posedge i_clk);
        if (idx <= CFG_Z_MIN) box_lo[idx] = value;
        else box_hi[idx - CFG_X_MAX] = value;
    endtask

    // Headers produce nothing, so allow the header latency after the last point.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_box(input longint lo [3], input longint hi [3]);
        wait_drained();
        for (int a = 0; a < 3; a++) begin
            write_reg(W_CFG_IDX'(CFG_X_MIN + a), lo[a]);
            write_reg(W_CFG_IDX'(CFG_X_MAX + a), hi[a]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic longint rand_coord(input bit full);
        longint v;
        v = longint'({$urandom, $urandom});
        if (full) return v >>> 24;
        return (v >>> 44);
    endfunction

    function automatic logic signed [W_ANG-1:0] rand_angle();
        case ($urandom_range(9))
            0: return W_ANG'($urandom);
            1: return W_ANG'($urandom_range(8) * DEG_QUARTER - DEG_CLAMP);
            default: return W_ANG'($urandom_range(2 * DEG_CLAMP) - DEG_CLAMP);
        endcase
    endfunction

    function automatic t_beam_item make_header(input int cnt);
        t_beam_item h;
        bit full;
        full = ($urandom_range(4) == 0);
        h.opc = OPC_HEADER;
        h.zen = rand_angle();
        h.az = rand_angle();
        h.cx = W_COORD'(rand_coord(full));
        h.cy = W_COORD'(rand_coord(full));
        h.cz = W_COORD'(rand_coord(full));
        h.cnt = W_CNT'(cnt);
        h.rng = W_RANGE'($urandom);
        h.refl = W_REFL'($urandom);
        return h;
    endfunction

    function automatic t_beam_item make_hit();
        t_beam_item h;
        h = make_header(0);
        h.opc = OPC_HIT;
        h.cnt = W_CNT'($urandom);
        h.rng = W_RANGE'(($urandom_range(4) == 0) ? $urandom : $urandom_range(1 << 22));
        return h;
    endfunction

    task automatic send_beam(input int cnt, input int surplus);
        send_item(make_header(cnt));
        repeat (cnt + surplus) send_item(make_hit());
    endtask

    task automatic test_directed();
        t_beam_item h;
        // Hits before any header are surplus.
        repeat (2) send_item(make_hit());
        h = make_header(3);
        h.zen = '0; h.az = '0; h.cx = '0; h.cy = '0; h.cz = '0;
        send_item(h);
        h = make_hit(); h.rng = '0; h.refl = 32'sh7fffffff; send_item(h);
        h = make_hit(); h.rng = '1; h.refl = 32'sh80000000; send_item(h);
        h = make_hit(); h.rng = 27'd65536; send_item(h);
        h = make_hit(); send_item(h);
        // Angles beyond one turn and centres at the limits saturate.
        h = make_header(2);
        h.zen = 26'sh1ffffff; h.az = 26'sh2000000;
        h.cx = W_COORD'(COORD_MAX); h.cy = W_COORD'(COORD_MIN); h.cz = W_COORD'(COORD_MAX);
        send_item(h);
        h = make_hit(); h.rng = '1; send_item(h);
        h = make_hit(); h.rng = '1; send_item(h);
        h = make_header(0);
        send_item(h);
        send_item(make_hit());
        h = make_header(5);
        h.zen = W_ANG'(DEG_QUARTER); h.az = W_ANG'(DEG_HALF);
        h.cx = W_COORD'(COORD_MIN); h.cy = W_COORD'(COORD_MIN); h.cz = W_COORD'(COORD_MIN);
        send_item(h);
        h = make_hit(); h.rng = '1; send_item(h);
        send_item(make_hit());
        // A new header cuts the beam short.
        h = make_header(2);
        h.zen = W_ANG'(-DEG_CLAMP); h.az = W_ANG'(DEG_CLAMP);
        send_item(h);
        repeat (3) send_item(make_hit());
    endtask

    task automatic test_boxes();
        longint lo [3], hi [3];
        for (int ph = 0; ph < 5; ph++) begin
            for (int a = 0; a < 3; a++) begin
                case (ph)
                    0: begin lo[a] = -(1 << 16); hi[a] = 1 << 16; end
                    1: begin lo[a] = 0; hi[a] = 0; end
                    2: begin lo[a] = COORD_MAX; hi[a] = COORD_MIN; end
                    3: begin lo[a] = COORD_MAX; hi[a] = COORD_MAX; end
                    default: begin
                        lo[a] = rand_coord(0) - (1 << 18);
                        hi[a] = lo[a] + $urandom_range(1 << 21);
                    end
                endcase
            end
            set_box(lo, hi);
            repeat (12) send_beam($urandom_range(8), $urandom_range(3) == 0);
        end
        for (int a = 0; a < 3; a++) begin
            lo[a] = COORD_MIN;
            hi[a] = COORD_MAX;
        end
        set_box(lo, hi);
    endtask

    task automatic test_long_beam();
        send_beam(255, 2);
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_cycles = 400;
        send_beam(40, 0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random();
        while (items_sent < 1150) begin
            case ($urandom_range(9))
                0:       send_item(make_hit());
                1:       send_beam($urandom_range(8), $urandom_range(1, 3));
                2:       send_beam($urandom_range(40, 9), 0);
                default: send_beam($urandom_range(8), 0);
            endcase
            if ($urandom_range(30) == 0) no_gaps = ~no_gaps;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= '0;
        i_cfg_data        <= '0;
        i_in_valid        <= 1'b0;
        i_opcode          <= OPC_HEADER;
        i_zenith_deg      <= '0;
        i_azimuth_deg     <= '0;
        i_centre_x        <= '0;
        i_centre_y        <= '0;
        i_centre_z        <= '0;
        i_hits_in_beam    <= '0;
        i_hit_range       <= '0;
        i_hit_reflectance <= '0;
        fail_count = 0;
        items_sent = 0;
        points_seen = 0;
        hold_cycles = 0;
        no_gaps = 1'b0;
        for (int a = 0; a < 3; a++) begin
            dir_f[a] = 0;
            held_ctr[a] = 0;
            box_lo[a] = COORD_MIN;
            box_hi[a] = COORD_MAX;
        end
        held_zen_rad = '0;
        held_az_rad = '0;
        beam_total = 0;
        hit_idx = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_boxes();
        test_long_beam();
        test_backpressure();
        test_random();

        wait_drained();
        $display("Sent %0d beam and hit requests and checked %0d points,", items_sent,
                 points_seen);
        $display("across open, empty, degenerate and random boxes with stalls on both sides.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### filelist.f
src/pbpbf_pkg.sv
src/pbpbf_ctrl.sv
src/pbpbf_dp.sv
src/polar_beam_to_point_box_filter_core.sv
tb/sv/polar_beam_to_point_box_filter_core_tb.sv
